@@ sv/lbp3_pkg.sv @@
`default_nettype none

package lbp3_pkg;

    localparam int PIXEL_W       = 8;
    localparam int CODE_W        = 8;
    localparam int WIDTH_W       = 11;
    localparam int HEIGHT_W      = 13;
    localparam int CFG_DATA_W    = 13;
    localparam int CFG_INDEX_W   = 1;
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int MAX_HEIGHT    = 4096;
    localparam int ROW_W         = $clog2(MAX_HEIGHT);
    localparam int MIN_SIZE      = 3;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(640);
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(480);

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              last;
    } lbp3_result_t;

endpackage

`default_nettype wire

@@ sv/lbp_3x3_stream.sv @@
// With the output queue empty, a pixel beat that completes a code is registered in the s1 stage,
// its code is then written into the output queue, and m_tvalid rises so the code can be taken.
// Throughput: one pixel beat per cycle while the output queue has room (else s_tready falls); each
// line store does one read and one write per cycle; a three-entry output queue keeps the input open.
// Reset (rst_n, asynchronous, active low) clears the counters, the window and the queue and
// loads the sizes 640 x 480; the line stores are not cleared and need no clearing pass.
`default_nettype none

module lbp_3x3_stream #(
    parameter int MAX_WIDTH = lbp3_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [lbp3_pkg::PIXEL_W-1:0]        s_tdata,   // [7:0] pixel
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [lbp3_pkg::CODE_W-1:0]              m_tdata,   // [7:0] lbp_code
    output logic                                     m_tlast,   // frame_last
    input  wire logic                                cfg_wen,
    input  wire logic [lbp3_pkg::CFG_INDEX_W-1:0]    cfg_addr,
    input  wire logic [lbp3_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    import lbp3_pkg::*;

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int WW   = CW + 1;
    localparam int WCMP = (WW > WIDTH_W) ? WW : WIDTH_W;
    localparam int QD   = 3;

    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;

    logic [CW-1:0]    col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    logic               s1_valid_reg;
    logic               s1_res_reg;
    logic               s1_last_reg;
    logic [CW-1:0]      s1_addr_reg;
    logic [PIXEL_W-1:0] s1_pixel_reg;

    logic [PIXEL_W-1:0] upper_mem  [MAX_WIDTH];
    logic [PIXEL_W-1:0] middle_mem [MAX_WIDTH];
    logic [PIXEL_W-1:0] upper_rd_reg;
    logic [PIXEL_W-1:0] middle_rd_reg;

    logic [PIXEL_W-1:0] win_reg  [9];
    logic [PIXEL_W-1:0] win_next [9];

    lbp3_result_t queue_reg [QD];
    logic [1:0]   head_reg, tail_reg, count_reg;

    logic [WCMP-1:0]     width_ext;
    logic [WW-1:0]       w_use;
    logic [HEIGHT_W-1:0] h_use;
    logic [WW-1:0]       col_ext;
    logic [HEIGHT_W-1:0] row_ext;
    logic                accept;
    logic                res_now;
    logic                last_now;
    logic                push;
    logic                pop;
    lbp3_result_t        result;
    logic [PIXEL_W-1:0]  ctr;

    // Sizes in use, saturated to the supported range.
    always_comb
    begin
        width_ext = WCMP'(width_reg);
        if (width_ext < WCMP'(MIN_SIZE))
            w_use = WW'(MIN_SIZE);
        else if (width_ext > WCMP'(MAX_WIDTH))
            w_use = WW'(MAX_WIDTH);
        else
            w_use = WW'(width_ext);
        if (height_reg < HEIGHT_W'(MIN_SIZE))
            h_use = HEIGHT_W'(MIN_SIZE);
        else if (height_reg > HEIGHT_W'(MAX_HEIGHT))
            h_use = HEIGHT_W'(MAX_HEIGHT);
        else
            h_use = height_reg;
    end

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (3'(count_reg) + 3'(s1_valid_reg)) <= 3'(QD - 1);
    assign col_ext  = WW'(col_reg);
    assign row_ext  = HEIGHT_W'(row_reg);
    assign res_now  = (row_reg >= ROW_W'(2)) && (col_reg >= CW'(2))
                      && (row_ext < h_use) && (col_ext < w_use);
    assign last_now = (row_ext == h_use - HEIGHT_W'(1)) && (col_ext == w_use - WW'(1));

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (col_ext + WW'(1) >= w_use)
            begin
                col_next = '0;
                if (row_ext + HEIGHT_W'(1) >= h_use)
                    row_next = '0;
                else
                    row_next = row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    // The window shifts left by one column; the new right column comes from the stores and the incoming pixel.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            win_next[k*3]     = win_reg[k*3 + 1];
            win_next[k*3 + 1] = win_reg[k*3 + 2];
        end
        win_next[2] = upper_rd_reg;
        win_next[5] = middle_rd_reg;
        win_next[8] = s1_pixel_reg;
        ctr = win_next[4];
        result.code[0] = win_next[0] > ctr;
        result.code[1] = win_next[1] > ctr;
        result.code[2] = win_next[2] > ctr;
        result.code[3] = win_next[5] > ctr;
        result.code[4] = win_next[8] > ctr;
        result.code[5] = win_next[7] > ctr;
        result.code[6] = win_next[6] > ctr;
        result.code[7] = win_next[3] > ctr;
        result.last    = s1_last_reg;
    end

    assign push     = s1_valid_reg && s1_res_reg;
    assign pop      = m_tvalid && m_tready;
    assign m_tvalid = count_reg != 2'd0;
    assign m_tdata  = queue_reg[head_reg].code;
    assign m_tlast  = queue_reg[head_reg].last;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            upper_rd_reg  <= upper_mem[col_reg];
            middle_rd_reg <= middle_mem[col_reg];
        end
        if (s1_valid_reg)
        begin
            upper_mem[s1_addr_reg]  <= middle_rd_reg;
            middle_mem[s1_addr_reg] <= s1_pixel_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_res_reg   <= res_now;
            s1_last_reg  <= last_now;
            s1_addr_reg  <= col_reg;
            s1_pixel_reg <= s_tdata;
        end
        if (push)
            queue_reg[tail_reg] <= result;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= WIDTH_RESET;
            height_reg   <= HEIGHT_RESET;
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            for (int k = 0; k < 9; k++)
                win_reg[k] <= '0;
        end
        else
        begin
            if (cfg_wen)
            begin
                case (cfg_addr)
                    REG_IMAGE_WIDTH:  width_reg  <= cfg_wdata[WIDTH_W-1:0];
                    REG_IMAGE_HEIGHT: height_reg <= cfg_wdata[HEIGHT_W-1:0];
                    default:          ;
                endcase
            end
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= accept;
            if (s1_valid_reg)
            begin
                for (int k = 0; k < 9; k++)
                    win_reg[k] <= win_next[k];
            end
            if (push)
                tail_reg <= (tail_reg == 2'(QD - 1)) ? 2'd0 : tail_reg + 2'd1;
            if (pop)
                head_reg <= (head_reg == 2'(QD - 1)) ? 2'd0 : head_reg + 2'd1;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

    // The queue never receives a beat while it is full.
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |-> (count_reg < 2'(QD)))
        else $error("output queue overflow");

    // A read of a line store never targets the entry being written back in the same cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s1_valid_reg) |-> (col_reg != s1_addr_reg))
        else $error("line store read and write-back collide");

    // After the last code of a frame the position counters start again at the origin.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && res_now && last_now) |=> (col_reg == '0 && row_reg == '0))
        else $error("counters did not rewrap at end of frame");

    // A result beat is only queued for an item that was accepted in the cycle before.
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> $past(accept))
        else $error("result queued without an accepted pixel");

endmodule

`default_nettype wire
